/* design/imh_pkg.sv */
// shared types, constants and step codes for the indexed min-heap
// no dependencies
package imh_pkg;

  localparam int MaxVertices = 1024;
  localparam int DistBits    = 31;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_DECKEY  = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [IdxW-1:0]     heap_index;
    logic [IdxW-1:0]     vertex;
    logic [DistBits-1:0] distance;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] min_vertex;
    logic            in_heap;
    logic            was_empty;
    logic [CntW-1:0] entries_left;
  } out_res_t;

  typedef struct packed {
    logic [IdxW-1:0]     vert;
    logic [DistBits-1:0] key;
  } entry_t;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_ACCEPT    = 5'd1;
  localparam op_t OP_LOAD      = 5'd2;
  localparam op_t OP_QRY_RD    = 5'd3;
  localparam op_t OP_EX_RDROOT = 5'd4;
  localparam op_t OP_EX_RDLAST = 5'd5;
  localparam op_t OP_EX_MOVE   = 5'd6;
  localparam op_t OP_EX_POS    = 5'd7;
  localparam op_t OP_SD_RDL    = 5'd8;
  localparam op_t OP_SD_RDR    = 5'd9;
  localparam op_t OP_SD_PICK   = 5'd10;
  localparam op_t OP_SD_SWAP   = 5'd11;
  localparam op_t OP_DK_RDP    = 5'd12;
  localparam op_t OP_DK_RDH    = 5'd13;
  localparam op_t OP_DK_WR     = 5'd14;
  localparam op_t OP_SU_RD     = 5'd15;
  localparam op_t OP_SU_CMP    = 5'd16;
  localparam op_t OP_SU_SWAP   = 5'd17;
  localparam op_t OP_FIN       = 5'd18;
  localparam op_t OP_FIN_EMPTY = 5'd19;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic l_ok;
    logic sd_move;
    logic idx_zero;
    logic su_move;
  } dp_stat_t;

endpackage

/* design/imh_dp.sv */
// datapath: heap and position memories, counters, compare logic, result register
// depends on imh_pkg
module imh_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  imh_pkg::in_req_t               in_data,
  input  logic                           cfg_we,
  input  logic [imh_pkg::CntW-1:0]       cfg_wdata,
  input  imh_pkg::dp_cmd_t               cmd,
  output imh_pkg::dp_stat_t              stat,
  output imh_pkg::out_res_t              res
);

  localparam int IdxW = imh_pkg::IdxW;
  localparam int CntW = imh_pkg::CntW;

  imh_pkg::entry_t heap_mem [imh_pkg::MaxVertices];
  logic [IdxW-1:0] pos_mem  [imh_pkg::MaxVertices];

  imh_pkg::entry_t   heap_q;
  logic [IdxW-1:0]   pos_q;

  imh_pkg::in_req_t  req_r;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [IdxW-1:0]   best_r, best_nxt;
  logic [IdxW-1:0]   rootv_r;
  imh_pkg::entry_t   cur_r, cur_nxt;
  imh_pkg::entry_t   lent_r, pent_r;
  imh_pkg::out_res_t res_r;

  logic              heap_we, heap_re, pos_we, pos_re;
  logic [IdxW-1:0]   heap_wa, heap_ra, pos_wa, pos_ra, pos_wd;
  imh_pkg::entry_t   heap_wd;

  logic [IdxW:0]     l_full;
  logic [IdxW+1:0]   r_full;
  logic              l_ok, r_ok, take_l, take_r;
  logic [IdxW-1:0]   parent;
  logic [IdxW-1:0]   pick_idx;
  imh_pkg::entry_t   pick_ent;
  logic [imh_pkg::DistBits-1:0] l_side_key;

  assign l_full = {idx_r, 1'b1};
  assign r_full = {1'b0, idx_r, 1'b0} + (IdxW+2)'(2);
  assign l_ok   = {1'b0, l_full} < {{(IdxW+2-CntW){1'b0}}, cnt_r};
  assign r_ok   = r_full < {{(IdxW+2-CntW){1'b0}}, cnt_r};
  assign parent = (idx_r - IdxW'(1)) >> 1;

  // left child wins only when strictly smaller, right is tested against the winner
  assign take_l     = l_ok && (lent_r.key < cur_r.key);
  assign l_side_key = take_l ? lent_r.key : cur_r.key;
  assign take_r     = r_ok && (heap_q.key < l_side_key);

  always_comb begin
    pick_idx = idx_r;
    pick_ent = cur_r;
    if (take_r) begin
      pick_idx = r_full[IdxW-1:0];
      pick_ent = heap_q;
    end else if (take_l) begin
      pick_idx = l_full[IdxW-1:0];
      pick_ent = lent_r;
    end
  end

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.l_ok     = l_ok;
  assign stat.sd_move  = take_l || take_r;
  assign stat.idx_zero = (idx_r == '0);
  assign stat.su_move  = req_r.distance < heap_q.key;

  always_comb begin
    heap_we = 1'b0;
    heap_re = 1'b0;
    pos_we  = 1'b0;
    pos_re  = 1'b0;
    heap_wa = idx_r;
    heap_ra = idx_r;
    heap_wd = cur_r;
    pos_wa  = cur_r.vert;
    pos_ra  = req_r.vertex;
    pos_wd  = idx_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    best_nxt = best_r;
    cur_nxt = cur_r;
    unique case (cmd.op)
      imh_pkg::OP_LOAD: begin
        heap_we = 1'b1;
        heap_wa = req_r.heap_index;
        heap_wd = '{vert: req_r.vertex, key: req_r.distance};
        pos_we  = 1'b1;
        pos_wa  = req_r.vertex;
        pos_wd  = req_r.heap_index;
      end
      imh_pkg::OP_QRY_RD, imh_pkg::OP_DK_RDP: begin
        pos_re = 1'b1;
      end
      imh_pkg::OP_EX_RDROOT: begin
        heap_re = 1'b1;
        heap_ra = '0;
      end
      imh_pkg::OP_EX_RDLAST: begin
        heap_re = 1'b1;
        heap_ra = IdxW'(cnt_r - CntW'(1));
      end
      imh_pkg::OP_EX_MOVE: begin
        // old root's slot becomes count-1, last entry moves to the root
        heap_we = 1'b1;
        heap_wa = '0;
        heap_wd = heap_q;
        pos_we  = 1'b1;
        pos_wa  = rootv_r;
        pos_wd  = IdxW'(cnt_r - CntW'(1));
        cnt_nxt = cnt_r - CntW'(1);
        idx_nxt = '0;
        cur_nxt = heap_q;
      end
      imh_pkg::OP_EX_POS: begin
        pos_we = 1'b1;
        pos_wa = cur_r.vert;
        pos_wd = '0;
      end
      imh_pkg::OP_SD_RDL: begin
        heap_re = 1'b1;
        heap_ra = l_full[IdxW-1:0];
      end
      imh_pkg::OP_SD_RDR: begin
        heap_re = 1'b1;
        heap_ra = r_full[IdxW-1:0];
      end
      imh_pkg::OP_SD_PICK: begin
        best_nxt = pick_idx;
        if (take_l || take_r) begin
          heap_we = 1'b1;
          heap_wa = idx_r;
          heap_wd = pick_ent;
          pos_we  = 1'b1;
          pos_wa  = pick_ent.vert;
          pos_wd  = idx_r;
        end
      end
      imh_pkg::OP_SD_SWAP: begin
        heap_we = 1'b1;
        heap_wa = best_r;
        heap_wd = cur_r;
        pos_we  = 1'b1;
        pos_wa  = cur_r.vert;
        pos_wd  = best_r;
        idx_nxt = best_r;
      end
      imh_pkg::OP_DK_RDH: begin
        heap_re = 1'b1;
        heap_ra = pos_q;
        idx_nxt = pos_q;
      end
      imh_pkg::OP_DK_WR: begin
        cur_nxt = '{vert: heap_q.vert, key: req_r.distance};
        heap_we = 1'b1;
        heap_wa = idx_r;
        heap_wd = '{vert: heap_q.vert, key: req_r.distance};
      end
      imh_pkg::OP_SU_RD: begin
        heap_re = 1'b1;
        heap_ra = parent;
      end
      imh_pkg::OP_SU_CMP: begin
        if (req_r.distance < heap_q.key) begin
          heap_we = 1'b1;
          heap_wa = idx_r;
          heap_wd = heap_q;
          pos_we  = 1'b1;
          pos_wa  = cur_r.vert;
          pos_wd  = parent;
        end
      end
      imh_pkg::OP_SU_SWAP: begin
        heap_we = 1'b1;
        heap_wa = parent;
        heap_wd = cur_r;
        pos_we  = 1'b1;
        pos_wa  = pent_r.vert;
        pos_wd  = idx_r;
        idx_nxt = parent;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    if (heap_re) begin
      heap_q <= heap_mem[heap_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (pos_re) begin
      pos_q <= pos_mem[pos_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= (cfg_wdata > CntW'(imh_pkg::MaxVertices)) ?
               CntW'(imh_pkg::MaxVertices) : cfg_wdata;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == imh_pkg::OP_ACCEPT) begin
      req_r <= in_data;
    end
    if (cmd.op == imh_pkg::OP_EX_RDLAST) begin
      rootv_r <= heap_q.vert;
    end
    if (cmd.op == imh_pkg::OP_SD_RDR) begin
      lent_r <= heap_q;
    end
    if (cmd.op == imh_pkg::OP_SU_CMP) begin
      pent_r <= heap_q;
    end
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    cur_r  <= cur_nxt;
    if (cmd.op == imh_pkg::OP_FIN || cmd.op == imh_pkg::OP_FIN_EMPTY) begin
      res_r.min_vertex   <= (req_r.cmd == imh_pkg::CMD_EXTRACT &&
                             cmd.op == imh_pkg::OP_FIN) ? rootv_r : '0;
      res_r.in_heap      <= (req_r.cmd == imh_pkg::CMD_QUERY) &&
                            ({{(CntW-IdxW){1'b0}}, pos_q} < cnt_r);
      res_r.was_empty    <= (cmd.op == imh_pkg::OP_FIN_EMPTY);
      res_r.entries_left <= cnt_r;
    end
  end

  assign res = res_r;

endmodule

/* design/imh_ctrl.sv */
// controller: sequences each command over the datapath and owns the handshakes
// depends on imh_pkg
module imh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  input  imh_pkg::dp_stat_t stat,
  output imh_pkg::dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_LOAD = 5'd1;
  localparam logic [4:0] S_QRD  = 5'd2;
  localparam logic [4:0] S_EX0  = 5'd3;
  localparam logic [4:0] S_EX1  = 5'd4;
  localparam logic [4:0] S_EX2  = 5'd5;
  localparam logic [4:0] S_EX3  = 5'd6;
  localparam logic [4:0] S_SD0  = 5'd7;
  localparam logic [4:0] S_SD1  = 5'd8;
  localparam logic [4:0] S_SD2  = 5'd9;
  localparam logic [4:0] S_SD3  = 5'd10;
  localparam logic [4:0] S_DK0  = 5'd11;
  localparam logic [4:0] S_DK1  = 5'd12;
  localparam logic [4:0] S_DK2  = 5'd13;
  localparam logic [4:0] S_SU0  = 5'd14;
  localparam logic [4:0] S_SU1  = 5'd15;
  localparam logic [4:0] S_SU2  = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;
  localparam logic [4:0] S_FINE = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = imh_pkg::OP_NONE;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = imh_pkg::OP_ACCEPT;
          unique case (in_cmd)
            imh_pkg::CMD_LOAD:    state_nxt = S_LOAD;
            imh_pkg::CMD_EXTRACT: state_nxt = stat.cnt_zero ? S_FINE : S_EX0;
            imh_pkg::CMD_DECKEY:  state_nxt = S_DK0;
            imh_pkg::CMD_QUERY:   state_nxt = S_QRD;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op = imh_pkg::OP_LOAD;
        state_nxt = S_FIN;
      end
      S_QRD: begin
        cmd.op = imh_pkg::OP_QRY_RD;
        state_nxt = S_FIN;
      end
      S_EX0: begin
        cmd.op = imh_pkg::OP_EX_RDROOT;
        state_nxt = S_EX1;
      end
      S_EX1: begin
        cmd.op = imh_pkg::OP_EX_RDLAST;
        state_nxt = S_EX2;
      end
      S_EX2: begin
        cmd.op = imh_pkg::OP_EX_MOVE;
        state_nxt = S_EX3;
      end
      S_EX3: begin
        cmd.op = imh_pkg::OP_EX_POS;
        state_nxt = S_SD0;
      end
      S_SD0: begin
        cmd.op = imh_pkg::OP_SD_RDL;
        state_nxt = stat.l_ok ? S_SD1 : S_FIN;
      end
      S_SD1: begin
        cmd.op = imh_pkg::OP_SD_RDR;
        state_nxt = S_SD2;
      end
      S_SD2: begin
        cmd.op = imh_pkg::OP_SD_PICK;
        state_nxt = stat.sd_move ? S_SD3 : S_FIN;
      end
      S_SD3: begin
        cmd.op = imh_pkg::OP_SD_SWAP;
        state_nxt = S_SD0;
      end
      S_DK0: begin
        cmd.op = imh_pkg::OP_DK_RDP;
        state_nxt = S_DK1;
      end
      S_DK1: begin
        cmd.op = imh_pkg::OP_DK_RDH;
        state_nxt = S_DK2;
      end
      S_DK2: begin
        cmd.op = imh_pkg::OP_DK_WR;
        state_nxt = S_SU0;
      end
      S_SU0: begin
        cmd.op = imh_pkg::OP_SU_RD;
        state_nxt = stat.idx_zero ? S_FIN : S_SU1;
      end
      S_SU1: begin
        cmd.op = imh_pkg::OP_SU_CMP;
        state_nxt = stat.su_move ? S_SU2 : S_FIN;
      end
      S_SU2: begin
        cmd.op = imh_pkg::OP_SU_SWAP;
        state_nxt = S_SU0;
      end
      S_FIN, S_FINE: begin
        // wait for the result register to free up
        if (slot_free) begin
          cmd.op = (state_r == S_FINE) ? imh_pkg::OP_FIN_EMPTY : imh_pkg::OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/indexed_min_heap_top.sv */
// indexed binary min-heap with decrease-key: top level joining controller and datapath
// depends on imh_pkg, imh_ctrl, imh_dp
// extract sifts the moved entry down and decrease key sifts the entry up, level by level;
// an empty extract skips the heap, and the finish step waits while out_ready holds the result
// reset (synchronous, rst_n low) clears the live count and control; memories are not cleared
module indexed_min_heap_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  imh_pkg::in_req_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output imh_pkg::out_res_t        out_data,
  input  logic                     cfg_we,
  input  logic [imh_pkg::CntW-1:0] cfg_wdata
);

  imh_pkg::dp_cmd_t  dp_cmd;
  imh_pkg::dp_stat_t dp_stat;

  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  imh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .res       (out_data)
  );

  // one request in flight: after an accept the input side closes
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_empty |->
      out_data.min_vertex == '0 && out_data.entries_left == '0 && !out_data.in_heap)
    else $error("empty extract result is inconsistent");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entries_left <= imh_pkg::CntW'(imh_pkg::MaxVertices))
    else $error("live count above capacity");

endmodule

/* sim/imh_checker.sv */
// request/result checker for the indexed min-heap: tracks the heap in its own state,
// predicts each result and compares it on the result channel
// depends on imh_pkg
module imh_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  imh_pkg::in_req_t         in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  imh_pkg::out_res_t        out_data,
  input  logic                     cfg_we,
  input  logic [imh_pkg::CntW-1:0] cfg_wdata,
  output int                       pending,
  output int                       errors
);

  logic [imh_pkg::IdxW-1:0]     slot_vert [imh_pkg::MaxVertices];
  logic [imh_pkg::DistBits-1:0] slot_dist [imh_pkg::MaxVertices];
  logic [imh_pkg::IdxW-1:0]     where_is  [imh_pkg::MaxVertices];
  int                           live;
  imh_pkg::out_res_t            due_q [$];

  initial begin
    for (int i = 0; i < imh_pkg::MaxVertices; i++) begin
      slot_vert[i] = '0;
      slot_dist[i] = '0;
      where_is[i]  = '0;
    end
    live    = 0;
    errors  = 0;
    pending = 0;
  end

  function automatic void swap_slots(int a, int b);
    logic [imh_pkg::IdxW-1:0]     tv;
    logic [imh_pkg::DistBits-1:0] td;
    tv = slot_vert[a]; td = slot_dist[a];
    slot_vert[a] = slot_vert[b]; slot_dist[a] = slot_dist[b];
    slot_vert[b] = tv; slot_dist[b] = td;
  endfunction

  function automatic imh_pkg::out_res_t heap_step(imh_pkg::in_req_t r);
    imh_pkg::out_res_t res;
    int i, p, best, last;
    logic [imh_pkg::IdxW-1:0] rootv;
    res = '0;
    case (r.cmd)
      imh_pkg::CMD_LOAD: begin
        slot_vert[r.heap_index] = r.vertex;
        slot_dist[r.heap_index] = r.distance;
        where_is[r.vertex] = r.heap_index;
      end
      imh_pkg::CMD_EXTRACT: begin
        if (live == 0) begin
          res.was_empty = 1'b1;
        end else begin
          last = live - 1;
          rootv = slot_vert[0];
          slot_vert[0] = slot_vert[last];
          slot_dist[0] = slot_dist[last];
          // root and last may be the same vertex: last write wins
          where_is[rootv] = imh_pkg::IdxW'(last);
          where_is[slot_vert[0]] = '0;
          live = last;
          i = 0;
          forever begin
            best = i;
            if (2 * i + 1 < live && slot_dist[2 * i + 1] < slot_dist[best]) best = 2 * i + 1;
            if (2 * i + 2 < live && slot_dist[2 * i + 2] < slot_dist[best]) best = 2 * i + 2;
            if (best == i) break;
            where_is[slot_vert[best]] = imh_pkg::IdxW'(i);
            where_is[slot_vert[i]] = imh_pkg::IdxW'(best);
            swap_slots(best, i);
            i = best;
          end
          res.min_vertex = rootv;
        end
      end
      imh_pkg::CMD_DECKEY: begin
        i = where_is[r.vertex];
        slot_dist[i] = r.distance;
        while (i != 0) begin
          p = (i - 1) / 2;
          if (!(r.distance < slot_dist[p])) break;
          where_is[slot_vert[i]] = imh_pkg::IdxW'(p);
          where_is[slot_vert[p]] = imh_pkg::IdxW'(i);
          swap_slots(i, p);
          i = p;
        end
      end
      default: begin
        res.in_heap = (int'(where_is[r.vertex]) < live);
      end
    endcase
    res.entries_left = imh_pkg::CntW'(live);
    return res;
  endfunction

  always @(posedge clk) begin
    imh_pkg::out_res_t want;
    if (!rst_n) begin
      live = 0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        live = (cfg_wdata > imh_pkg::MaxVertices) ? imh_pkg::MaxVertices : int'(cfg_wdata);
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, out_data);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (out_data.min_vertex !== want.min_vertex || out_data.in_heap !== want.in_heap ||
              out_data.was_empty !== want.was_empty ||
              out_data.entries_left !== want.entries_left) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) due_q = {due_q, heap_step(in_data)};
    end
    pending = due_q.size();
  end

endmodule

/* sim/tb_indexed_min_heap_top.sv */
// testbench top for indexed_min_heap_top: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict; depends on imh_pkg, imh_checker and indexed_min_heap_top
module tb_indexed_min_heap_top;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  imh_pkg::in_req_t         in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  imh_pkg::out_res_t        out_data;
  logic                     cfg_we = 1'b0;
  logic [imh_pkg::CntW-1:0] cfg_wdata = '0;
  int                       pending, errors;

  bit                       calm = 1'b0;
  bit                       want_hold = 1'b0;
  int                       hold_left = 0;
  int                       quiet_cycles = 0;
  int                       filled = 0;
  bit                       vert_known [imh_pkg::MaxVertices];
  logic [imh_pkg::IdxW-1:0] known_q [$];
  int                       perm [imh_pkg::MaxVertices];

  indexed_min_heap_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata
  );

  imh_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata,
    .pending, .errors
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (want_hold) begin
      want_hold = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 3000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [imh_pkg::DistBits-1:0] pick_dist();
    case ($urandom_range(0, 7))
      0, 1:    return imh_pkg::DistBits'($urandom_range(0, 15));
      2:       return '1;
      3:       return '0;
      default: return imh_pkg::DistBits'($urandom());
    endcase
  endfunction

  task automatic push_req(logic [1:0] c, int hidx, int v, logic [imh_pkg::DistBits-1:0] d);
    imh_pkg::in_req_t r;
    r.cmd = c;
    r.heap_index = imh_pkg::IdxW'(hidx);
    r.vertex = imh_pkg::IdxW'(v);
    r.distance = d;
    if (c == imh_pkg::CMD_LOAD && !vert_known[v]) begin
      vert_known[v] = 1'b1;
      known_q = {known_q, imh_pkg::IdxW'(v)};
    end
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the block drain before touching the register
  task automatic write_count(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= imh_pkg::CntW'(n);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // load slots 0..n-1 with distinct random vertices
  task automatic fill_heap(int n);
    int j, t;
    for (int i = 0; i < imh_pkg::MaxVertices; i++) perm[i] = i;
    for (int i = 0; i < n; i++) begin
      j = $urandom_range(i, imh_pkg::MaxVertices - 1);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
      push_req(imh_pkg::CMD_LOAD, i, perm[i], pick_dist());
    end
    if (n > filled) filled = n;
  endtask

  task automatic run_ops(int n, bit pressure);
    int roll;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == 20) want_hold = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 35)
        push_req(imh_pkg::CMD_EXTRACT, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 pick_dist());
      else if (roll < 65)
        push_req(imh_pkg::CMD_DECKEY, $urandom_range(0, 1023),
                 known_q[$urandom_range(0, known_q.size() - 1)], pick_dist());
      else if (roll < 85)
        push_req(imh_pkg::CMD_QUERY, $urandom_range(0, 1023),
                 known_q[$urandom_range(0, known_q.size() - 1)], pick_dist());
      else
        push_req(imh_pkg::CMD_LOAD, $urandom_range(0, filled - 1), $urandom_range(0, 1023),
                 pick_dist());
    end
  endtask

  initial begin
    for (int i = 0; i < imh_pkg::MaxVertices; i++) vert_known[i] = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // empty heap, then a four-entry heap walked through every command
    write_count(0);
    push_req(imh_pkg::CMD_EXTRACT, 0, 0, '0);
    write_count(4);
    push_req(imh_pkg::CMD_LOAD, 0, 1023, '1);
    push_req(imh_pkg::CMD_LOAD, 1, 0, '0);
    push_req(imh_pkg::CMD_LOAD, 2, 5, 10);
    push_req(imh_pkg::CMD_LOAD, 3, 6, 10);
    push_req(imh_pkg::CMD_QUERY, 0, 1023, '0);
    push_req(imh_pkg::CMD_DECKEY, 0, 1023, 3);
    push_req(imh_pkg::CMD_DECKEY, 0, 5, 100);
    push_req(imh_pkg::CMD_EXTRACT, 0, 0, '0);
    push_req(imh_pkg::CMD_QUERY, 0, 0, '0);
    // decrease key on vertex 0, which is still in the heap, now at the root
    push_req(imh_pkg::CMD_DECKEY, 0, 0, 1);
    push_req(imh_pkg::CMD_EXTRACT, 0, 0, '0);
    push_req(imh_pkg::CMD_EXTRACT, 0, 0, '0);
    push_req(imh_pkg::CMD_EXTRACT, 0, 0, '0);
    push_req(imh_pkg::CMD_QUERY, 0, 6, '0);
    push_req(imh_pkg::CMD_EXTRACT, 0, 0, '0);
    filled = 4;

    // oversized count saturates to full size; a query shows it without touching the heap
    write_count(2047);
    push_req(imh_pkg::CMD_QUERY, 0, 6, '0);

    // fill without idling, then run under a long result hold-off
    write_count(100);
    calm = 1'b1;
    fill_heap(100);
    calm = 1'b0;
    run_ops(120, 1'b1);

    for (int k = 0; k < 3; k++) begin
      write_count(k == 0 ? 1 : $urandom_range(2, 20));
      fill_heap(k == 0 ? 1 : int'(cfg_wdata));
      run_ops(30, 1'b0);
    end
    write_count(filled);
    run_ops(25, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/imh_pkg.sv
design/imh_dp.sv
design/imh_ctrl.sv
design/indexed_min_heap_top.sv
sim/imh_checker.sv
sim/tb_indexed_min_heap_top.sv
